/* hw/rtl/ihex_pkg.sv */
// Shared types, constants and a helper function for the Intel HEX record decoder.
package ihex_pkg;

  // Field widths of the two channels.
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ADDR_W   = 33;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;

  // Widths and saturation limits of the per-line counters.
  localparam int unsigned LINE_W   = 10;
  localparam int unsigned COUNT_W  = 9;
  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Shortest legal line, colon included.
  localparam logic [LINE_W-1:0] LINE_MIN = LINE_W'(11);

  // Header bytes ahead of the data field, and header plus checksum.
  localparam logic [COUNT_W-1:0] HDR_BYTES   = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] FRAME_BYTES = COUNT_W'(5);

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  // Record types the decoder acts on.
  localparam logic [BYTE_W-1:0] KIND_DATA    = 8'h00;
  localparam logic [BYTE_W-1:0] KIND_EOF     = 8'h01;
  localparam logic [BYTE_W-1:0] KIND_EXT_SEG = 8'h02;
  localparam logic [BYTE_W-1:0] KIND_EXT_LIN = 8'h04;

  // Header and extended-address byte positions within a record.
  localparam logic [COUNT_W-1:0] IDX_LEN     = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] IDX_OFS_HI  = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] IDX_OFS_LO  = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] IDX_KIND    = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] IDX_BASE_HI = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] IDX_BASE_LO = COUNT_W'(5);

  // Record verdict codes, in priority order.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_LINE_LEN = 3'd1,
    ST_NO_COLON = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_LEN_BYTE = 3'd5,
    ST_EXT_LEN  = 3'd6
  } ihex_status_t;

  // Result kinds.
  typedef enum logic {
    RK_DATA    = 1'b0,
    RK_VERDICT = 1'b1
  } ihex_kind_t;

  // One result item as it travels to the output register.
  typedef struct packed {
    ihex_kind_t          kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    logic [BYTE_W-1:0]   rtype;
    ihex_status_t        status;
  } ihex_result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [4:0] d;
    d = 5'd0;
    if (c >= "0" && c <= "9") begin
      d = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      d = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      d = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return d;
  endfunction

endpackage

/* hw/rtl/ihex_in_stage.sv */
// Input register that holds one accepted character until the decoder takes it.
module ihex_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ihex_pkg::CHAR_W-1:0] in_text_char,
  input  logic                        take,
  output logic                        char_vld,
  output logic [ihex_pkg::CHAR_W-1:0] char_val
);

  logic                        vld_r;
  logic                        vld_nxt;
  logic [ihex_pkg::CHAR_W-1:0] char_r;
  logic                        load;

  // Stall only while a held character cannot move on this cycle.
  assign in_stall = vld_r & ~take;
  assign load     = in_valid & ~in_stall;
  assign vld_nxt  = load | (vld_r & ~take);

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Character payload.
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= in_text_char;
    end
  end

  assign char_vld = vld_r;
  assign char_val = char_r;

endmodule

/* hw/rtl/ihex_record.sv */
// Per-character record state, checksum, verdicts and data byte addressing.
module ihex_record (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [ihex_pkg::CHAR_W-1:0] c,
  output logic                        res_vld,
  output ihex_pkg::ihex_result_t      res
);

  logic                          halted_r,     halted_nxt;
  logic [ihex_pkg::LINE_W-1:0]   line_chars_r, line_chars_nxt;
  logic                          colon_r,      colon_nxt;
  logic                          hex_bad_r,    hex_bad_nxt;
  logic                          half_r,       half_nxt;
  logic [3:0]                    high_nib_r,   high_nib_nxt;
  logic [ihex_pkg::COUNT_W-1:0]  count_r,      count_nxt;
  logic [7:0]                    sum_r,        sum_nxt;
  logic [7:0]                    rec_len_r,    rec_len_nxt;
  logic [15:0]                   rec_ofs_r,    rec_ofs_nxt;
  logic [7:0]                    rec_kind_r,   rec_kind_nxt;
  logic [15:0]                   pend_base_r,  pend_base_nxt;
  logic [31:0]                   base_r,       base_nxt;

  logic [4:0]                    dig;
  logic [7:0]                    byte_val;
  logic [ihex_pkg::COUNT_W-1:0]  data_idx;
  logic [ihex_pkg::COUNT_W-1:0]  len_ext;
  logic                          is_ext;
  ihex_pkg::ihex_status_t        verdict;

  assign dig      = ihex_pkg::hex_digit(c);
  assign byte_val = {high_nib_r, dig[3:0]};
  assign data_idx = count_r - ihex_pkg::HDR_BYTES;
  assign len_ext  = {1'b0, rec_len_r};
  assign is_ext   = (rec_kind_r == ihex_pkg::KIND_EXT_SEG) ||
                    (rec_kind_r == ihex_pkg::KIND_EXT_LIN);

  // Verdict in priority order, judged from the state at the newline.
  always_comb begin
    if (line_chars_r < ihex_pkg::LINE_MIN || half_r) begin
      verdict = ihex_pkg::ST_LINE_LEN;
    end else if (!colon_r) begin
      verdict = ihex_pkg::ST_NO_COLON;
    end else if (hex_bad_r) begin
      verdict = ihex_pkg::ST_BAD_HEX;
    end else if (sum_r != 8'd0) begin
      verdict = ihex_pkg::ST_CHECKSUM;
    end else if (count_r != len_ext + ihex_pkg::FRAME_BYTES) begin
      verdict = ihex_pkg::ST_LEN_BYTE;
    end else if (is_ext && rec_len_r != 8'd2) begin
      verdict = ihex_pkg::ST_EXT_LEN;
    end else begin
      verdict = ihex_pkg::ST_OK;
    end
  end

  // Next state and the result of one character.
  always_comb begin
    halted_nxt     = halted_r;
    line_chars_nxt = line_chars_r;
    colon_nxt      = colon_r;
    hex_bad_nxt    = hex_bad_r;
    half_nxt       = half_r;
    high_nib_nxt   = high_nib_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    rec_len_nxt    = rec_len_r;
    rec_ofs_nxt    = rec_ofs_r;
    rec_kind_nxt   = rec_kind_r;
    pend_base_nxt  = pend_base_r;
    base_nxt       = base_r;
    res_vld        = 1'b0;
    res.kind       = ihex_pkg::RK_DATA;
    res.addr       = ihex_pkg::ADDR_W'(base_r) + ihex_pkg::ADDR_W'(rec_ofs_r) +
                     ihex_pkg::ADDR_W'(data_idx[7:0]);
    res.data       = byte_val;
    res.rtype      = 8'd0;
    res.status     = ihex_pkg::ST_OK;

    if (step && !halted_r && c != ihex_pkg::CH_CR) begin
      if (c == ihex_pkg::CH_LF) begin
        // End of a non-empty line: verdict, then base update or halt, then clear the line.
        if (line_chars_r != '0) begin
          res_vld    = 1'b1;
          res.kind   = ihex_pkg::RK_VERDICT;
          res.addr   = '0;
          res.data   = 8'd0;
          res.rtype  = rec_kind_r;
          res.status = verdict;
          if (verdict != ihex_pkg::ST_OK) begin
            halted_nxt = 1'b1;
          end else if (rec_kind_r == ihex_pkg::KIND_EXT_SEG) begin
            base_nxt = {12'd0, pend_base_r, 4'd0};
          end else if (rec_kind_r == ihex_pkg::KIND_EXT_LIN) begin
            base_nxt = {pend_base_r, 16'd0};
          end
          line_chars_nxt = '0;
          colon_nxt      = 1'b0;
          hex_bad_nxt    = 1'b0;
          half_nxt       = 1'b0;
          high_nib_nxt   = 4'd0;
          count_nxt      = '0;
          sum_nxt        = 8'd0;
          rec_len_nxt    = 8'd0;
          rec_kind_nxt   = 8'd0;
        end
      end else if (line_chars_r == '0) begin
        // First character of a line is only checked for the colon.
        colon_nxt      = (c == ihex_pkg::CH_COLON);
        line_chars_nxt = ihex_pkg::LINE_W'(1);
      end else begin
        if (line_chars_r != ihex_pkg::LINE_MAX) begin
          line_chars_nxt = line_chars_r + 1'b1;
        end
        hex_bad_nxt = hex_bad_r | ~dig[4];
        if (!half_r) begin
          // First digit of a pair.
          half_nxt = 1'b1;
          if (dig[4]) begin
            high_nib_nxt = dig[3:0];
          end
        end else begin
          // Second digit completes a byte.
          half_nxt = 1'b0;
          if (!hex_bad_nxt && colon_r) begin
            if (count_r != ihex_pkg::COUNT_MAX) begin
              count_nxt = count_r + 1'b1;
            end
            sum_nxt = sum_r + byte_val;
            unique case (count_r)
              ihex_pkg::IDX_LEN:     rec_len_nxt   = byte_val;
              ihex_pkg::IDX_OFS_HI:  rec_ofs_nxt   = {byte_val, rec_ofs_r[7:0]};
              ihex_pkg::IDX_OFS_LO:  rec_ofs_nxt   = {rec_ofs_r[15:8], byte_val};
              ihex_pkg::IDX_KIND:    rec_kind_nxt  = byte_val;
              ihex_pkg::IDX_BASE_HI: pend_base_nxt = {byte_val, pend_base_r[7:0]};
              ihex_pkg::IDX_BASE_LO: pend_base_nxt = {pend_base_r[15:8], byte_val};
              default: ;
            endcase
            // Data bytes of a data record go out as tentative results.
            if (count_r >= ihex_pkg::HDR_BYTES && rec_kind_r == ihex_pkg::KIND_DATA &&
                data_idx < len_ext) begin
              res_vld = 1'b1;
            end
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r     <= 1'b0;
      line_chars_r <= '0;
      colon_r      <= 1'b0;
      hex_bad_r    <= 1'b0;
      half_r       <= 1'b0;
      high_nib_r   <= 4'd0;
      count_r      <= '0;
      sum_r        <= 8'd0;
      rec_len_r    <= 8'd0;
      rec_ofs_r    <= 16'd0;
      rec_kind_r   <= 8'd0;
      pend_base_r  <= 16'd0;
      base_r       <= 32'd0;
    end else begin
      halted_r     <= halted_nxt;
      line_chars_r <= line_chars_nxt;
      colon_r      <= colon_nxt;
      hex_bad_r    <= hex_bad_nxt;
      half_r       <= half_nxt;
      high_nib_r   <= high_nib_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
      rec_len_r    <= rec_len_nxt;
      rec_ofs_r    <= rec_ofs_nxt;
      rec_kind_r   <= rec_kind_nxt;
      pend_base_r  <= pend_base_nxt;
      base_r       <= base_nxt;
    end
  end

endmodule

/* hw/rtl/ihex_out_stage.sv */
// Result register that holds one result until the downstream side takes it.
module ihex_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_vld,
  input  ihex_pkg::ihex_result_t res,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ihex_pkg::ihex_result_t out_res
);

  logic                   vld_r;
  logic                   vld_nxt;
  ihex_pkg::ihex_result_t res_r;

  // The register can load when empty or when its result is transferred now.
  assign ready   = ~vld_r | ~out_stall;
  assign vld_nxt = ready ? res_vld : vld_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ready && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

/* hw/rtl/intel_hex_record_decoder_top.sv */
// Top level of the Intel HEX record decoder: input register, record logic, result register.
//
//   Channel | Direction | Ports                                      | Transfer
//   --------+-----------+--------------------------------------------+--------------------
//   in_     | input     | in_valid, in_stall, in_text_char           | valid & !stall
//   out_    | output    | out_valid, out_stall, out_result_kind,     | valid & !stall
//           |           | out_byte_address, out_data_byte,           |
//           |           | out_record_type, out_status                |
//
// One character is taken per cycle while in_stall is low; it is held in the input register and
// its result, if any, in the result register. The path between the two registers holds a
// three-term 33-bit address sum.
// Synchronous active-low reset clears the line state, the base address and the halt flag.
// A stalled result register holds the character in the input register, and in_stall rises
// only while both registers are full and out_stall is high.
module intel_hex_record_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ihex_pkg::CHAR_W-1:0]   in_text_char,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [ihex_pkg::ADDR_W-1:0]   out_byte_address,
  output logic [ihex_pkg::BYTE_W-1:0]   out_data_byte,
  output logic [ihex_pkg::BYTE_W-1:0]   out_record_type,
  output logic [ihex_pkg::STATUS_W-1:0] out_status
);

  logic                        ready;
  logic                        char_vld;
  logic [ihex_pkg::CHAR_W-1:0] char_val;
  logic                        res_vld;
  ihex_pkg::ihex_result_t      res;
  ihex_pkg::ihex_result_t      out_res;

  // Input register.
  ihex_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_char (in_text_char),
    .take         (ready),
    .char_vld     (char_vld),
    .char_val     (char_val)
  );

  // Record decode logic.
  ihex_record u_rec (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (char_vld & ready),
    .c       (char_val),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register.
  ihex_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind  = out_res.kind;
  assign out_byte_address = out_res.addr;
  assign out_data_byte    = out_res.data;
  assign out_record_type  = out_res.rtype;
  assign out_status       = out_res.status;

endmodule
